/* hw/rtl/twr_pkg.sv */
// Shared types and constants for the TFTP write receiver.
package twr_pkg;

  localparam int MaxPacketDef  = 516;
  localparam int BlockBytesDef = 512;
  localparam int NameBytesDef  = 256;
  localparam int QueueDepthDef = 4;

  // TFTP opcodes as they appear in the first two bytes of a packet.
  localparam logic [15:0] OP_WRQ     = 16'd2;
  localparam logic [15:0] OP_DATA    = 16'd3;
  localparam logic [15:0] OP_ERR_PKT = 16'd5;

  // TFTP wire error codes.
  localparam logic [2:0] ERR_ACCESS  = 3'd2;
  localparam logic [2:0] ERR_DISK    = 3'd3;
  localparam logic [2:0] ERR_ILLEGAL = 3'd4;
  localparam logic [2:0] ERR_NONE    = 3'd0;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_NAME  = 2'd1,
    KIND_ACK   = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_NAME = 2'd0,
    PH_MODE = 2'd1,
    PH_DONE = 2'd2,
    PH_LONG = 2'd3
  } phase_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [15:0] block;
    logic [2:0]  code;
    logic        over;
  } res_t;

  // One queue entry: the results caused by one input byte, first one in r0.
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

endpackage

/* hw/rtl/twr_ifs.sv */
// Handshake channels for the receive bytes and the produced results.
interface twr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       rx_last;
  logic       sink_fault;

  modport source (output valid, output rx_byte, output rx_last, output sink_fault,
                  input ready);
  modport sink (input valid, input rx_byte, input rx_last, input sink_fault,
                output ready);
endinterface

interface twr_tx_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte;
  logic [15:0] out_block;
  logic [2:0]  out_error_code;
  logic        transfer_over;
  logic        out_last;

  modport source (output valid, output out_kind, output out_byte, output out_block,
                  output out_error_code, output transfer_over, output out_last,
                  input ready);
  modport sink (input valid, input out_kind, input out_byte, input out_block,
                input out_error_code, input transfer_over, input out_last,
                output ready);
endinterface

/* hw/rtl/twr_front.sv */
// Packet parser: tracks the protocol state and classifies each received byte.
module twr_front import twr_pkg::*; #(
  parameter int MaxPacket  = MaxPacketDef,
  parameter int BlockBytes = BlockBytesDef,
  parameter int NameBytes  = NameBytesDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   accept_i,
  input  logic [7:0] rx_byte_i,
  input  logic   rx_last_i,
  input  logic   sink_fault_i,
  output logic   push_o,
  output entry_t entry_o
);

  localparam int IdxW     = $clog2(MaxPacket + 1);
  localparam int NameW    = $clog2(NameBytes);
  localparam int ShortLim = BlockBytes + 4;

  logic             in_tr_q, in_tr_d;
  logic [15:0]      exp_q, exp_d;
  logic [IdxW-1:0]  idx_q, idx_d, idx_s;
  logic [15:0]      op_q, op_d, op_s;
  logic [15:0]      blk_q, blk_d, blk_s;
  logic [NameW-1:0] name_q, name_d, name_s;
  phase_e           ph_q, ph_d, ph_s;

  logic has_b, has_e;
  res_t res_b, res_e;

  // Per-byte step: position bookkeeping and the byte's own result.
  always_comb begin
    idx_s  = idx_q;
    op_s   = op_q;
    blk_s  = blk_q;
    name_s = name_q;
    ph_s   = ph_q;
    has_b  = 1'b0;
    res_b  = '{kind: KIND_DATA, data: rx_byte_i, block: 16'd0, code: ERR_NONE, over: 1'b0};
    if (accept_i && idx_q < IdxW'(MaxPacket)) begin
      idx_s = idx_q + IdxW'(1);
      if (idx_q < IdxW'(2)) begin
        op_s = {op_q[7:0], rx_byte_i};
      end else if (in_tr_q) begin
        if (idx_q < IdxW'(4)) begin
          blk_s = {blk_q[7:0], rx_byte_i};
        end else if (op_q == OP_DATA && blk_q == exp_q) begin
          has_b = 1'b1;
        end
      end else if (op_q == OP_WRQ) begin
        unique case (ph_q)
          PH_NAME: begin
            if (rx_byte_i == 8'd0) begin
              ph_s = PH_MODE;
            end else if (name_q >= NameW'(NameBytes - 1)) begin
              ph_s = PH_LONG;
            end else begin
              name_s     = name_q + NameW'(1);
              has_b      = 1'b1;
              res_b.kind = KIND_NAME;
            end
          end
          PH_MODE: begin
            if (rx_byte_i == 8'd0) begin
              ph_s = PH_DONE;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Packet end: answer decision and the transfer state.
  always_comb begin
    in_tr_d = in_tr_q;
    exp_d   = exp_q;
    idx_d   = idx_s;
    op_d    = op_s;
    blk_d   = blk_s;
    name_d  = name_s;
    ph_d    = ph_s;
    has_e   = 1'b0;
    res_e   = '{kind: KIND_ACK, data: 8'd0, block: 16'd0, code: ERR_NONE, over: 1'b0};
    if (accept_i && rx_last_i) begin
      if (!in_tr_q) begin
        if (idx_s >= IdxW'(6) && op_s == OP_WRQ && ph_s == PH_DONE) begin
          has_e = 1'b1;
          if (sink_fault_i) begin
            res_e.kind = KIND_ERROR;
            res_e.code = ERR_ACCESS;
            res_e.over = 1'b1;
          end else begin
            in_tr_d = 1'b1;
            exp_d   = 16'd1;
          end
        end
      end else if (idx_s < IdxW'(4)) begin
        in_tr_d = 1'b0;
      end else if (op_s == OP_DATA && blk_s == exp_q) begin
        has_e = 1'b1;
        if (sink_fault_i && idx_s > IdxW'(4)) begin
          res_e.kind = KIND_ERROR;
          res_e.code = ERR_DISK;
          res_e.over = 1'b1;
          in_tr_d    = 1'b0;
        end else if (32'(idx_s) < ShortLim) begin
          res_e.block = exp_q;
          res_e.over  = 1'b1;
          in_tr_d     = 1'b0;
        end else begin
          res_e.block = exp_q;
          exp_d       = exp_q + 16'd1;
        end
      end else if (op_s == OP_DATA && blk_s < exp_q) begin
        has_e       = 1'b1;
        res_e.block = blk_s;
      end else if (op_s == OP_ERR_PKT) begin
        in_tr_d = 1'b0;
      end else begin
        has_e      = 1'b1;
        res_e.kind = KIND_ERROR;
        res_e.code = ERR_ILLEGAL;
        res_e.over = 1'b1;
        in_tr_d    = 1'b0;
      end
      idx_d  = '0;
      op_d   = '0;
      blk_d  = '0;
      name_d = '0;
      ph_d   = PH_NAME;
    end
  end

  always_comb begin
    push_o = has_b || has_e;
    if (has_b) begin
      entry_o = '{two: has_e, r0: res_b, r1: res_e};
    end else begin
      entry_o = '{two: 1'b0, r0: res_e, r1: res_e};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_tr_q <= 1'b0;
      exp_q   <= 16'd1;
      idx_q   <= '0;
      op_q    <= '0;
      blk_q   <= '0;
      name_q  <= '0;
      ph_q    <= PH_NAME;
    end else begin
      in_tr_q <= in_tr_d;
      exp_q   <= exp_d;
      idx_q   <= idx_d;
      op_q    <= op_d;
      blk_q   <= blk_d;
      name_q  <= name_d;
      ph_q    <= ph_d;
    end
  end

endmodule

/* hw/rtl/twr_queue.sv */
// Small first-in first-out queue of result entries between parser and output.
module twr_queue import twr_pkg::*; #(
  parameter int Depth = QueueDepthDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  input  logic   pop_i,
  output entry_t entry_o,
  output logic   full_o,
  output logic   empty_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

/* hw/rtl/twr_back.sv */
// Output stage: splits queue entries into single results behind a register.
module twr_back import twr_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  entry_t entry_i,
  input  logic   empty_i,
  output logic   pop_o,
  input  logic   ready_i,
  output logic   valid_o,
  output res_t   res_o,
  output logic   last_o
);

  logic valid_q, last_q, sec_q;
  res_t res_q, hold_q;
  logic slot_free;

  assign slot_free = !valid_q || ready_i;
  assign pop_o     = slot_free && !sec_q && !empty_i;
  assign valid_o   = valid_q;
  assign res_o     = res_q;
  assign last_o    = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sec_q   <= 1'b0;
    end else if (slot_free) begin
      if (sec_q) begin
        valid_q <= 1'b1;
        sec_q   <= 1'b0;
      end else begin
        valid_q <= !empty_i;
        sec_q   <= !empty_i && entry_i.two;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free) begin
      if (sec_q) begin
        res_q  <= hold_q;
        last_q <= 1'b1;
      end else begin
        res_q  <= entry_i.r0;
        last_q <= !entry_i.two;
        hold_q <= entry_i.r1;
      end
    end
  end

endmodule

/* hw/rtl/tftp_write_receiver.sv */
// Top level of the TFTP write-request receiver with stop-and-wait acknowledge.
//
// Channel | Direction | Payload                                      | Handshake
// rx_i    | in        | rx_byte, rx_last, sink_fault                 | valid/ready
// tx_o    | out       | out_kind, out_byte, out_block, out_error_code,| valid/ready
//         |           | transfer_over, out_last                      |
//
// One received byte is taken in every cycle while the result queue has room.
// A byte that causes results is written into the result queue when it is
// accepted and then moved into the output register, from which it can be
// taken. Results leave at one per cycle while tx_o is ready, so the two
// results of one byte (the last data byte followed by its ack) leave one
// after the other. The result queue absorbs these bursts and output
// stalls; input stalls only when the queue is full. Reset is asynchronous
// and clears all control state at once, with no clearing pass.
module tftp_write_receiver import twr_pkg::*; #(
  parameter int MaxPacket  = MaxPacketDef,
  parameter int BlockBytes = BlockBytesDef,
  parameter int NameBytes  = NameBytesDef,
  parameter int QueueDepth = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  twr_rx_if.sink   rx_i,
  twr_tx_if.source tx_o
);

  logic   accept;
  logic   push;
  entry_t push_entry;
  entry_t head_entry;
  logic   q_full, q_empty, pop;
  res_t   res;
  logic   res_last;

  // The parser advances on every accepted byte; ready only needs queue room.
  assign rx_i.ready = !q_full;
  assign accept     = rx_i.valid && !q_full;

  twr_front #(
    .MaxPacket (MaxPacket),
    .BlockBytes(BlockBytes),
    .NameBytes (NameBytes)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_i.rx_byte),
    .rx_last_i   (rx_i.rx_last),
    .sink_fault_i(rx_i.sink_fault),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  twr_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .pop_i  (pop),
    .entry_o(head_entry),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  twr_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .entry_i(head_entry),
    .empty_i(q_empty),
    .pop_o  (pop),
    .ready_i(tx_o.ready),
    .valid_o(tx_o.valid),
    .res_o  (res),
    .last_o (res_last)
  );

  // Result fields go straight from the output register to the port.
  assign tx_o.out_kind       = res.kind;
  assign tx_o.out_byte       = res.data;
  assign tx_o.out_block      = res.block;
  assign tx_o.out_error_code = res.code;
  assign tx_o.transfer_over  = res.over;
  assign tx_o.out_last       = res_last;

endmodule

/* hw/rtl/twr_checker.sv */
// Port-level checks of the result channel, bound to the top level.
module twr_checker import twr_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        ready_i,
  input logic [1:0]  kind_i,
  input logic [15:0] block_i,
  input logic [2:0]  code_i,
  input logic        over_i,
  input logic        last_i
);

  logic is_byte, is_end;
  assign is_byte = (kind_i == KIND_DATA) || (kind_i == KIND_NAME);
  assign is_end  = (kind_i == KIND_ACK) || (kind_i == KIND_ERROR);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(kind_i) && $stable(block_i))
    else $error("result changed while stalled");

  a_byte_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && is_byte |-> block_i == 16'd0 && code_i == ERR_NONE && !over_i)
    else $error("byte result carries packet-end fields");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && is_end |-> last_i)
    else $error("ack or error is not the final result of its byte");

  a_error_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && kind_i == KIND_ERROR |->
      over_i && (code_i == ERR_ACCESS || code_i == ERR_DISK || code_i == ERR_ILLEGAL))
    else $error("error result with bad code or open transfer");

endmodule

bind tftp_write_receiver twr_checker u_twr_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .valid_i(tx_o.valid),
  .ready_i(tx_o.ready),
  .kind_i (tx_o.out_kind),
  .block_i(tx_o.out_block),
  .code_i (tx_o.out_error_code),
  .over_i (tx_o.transfer_over),
  .last_i (tx_o.out_last)
);

/* dv/wrq_transfer_checker.sv */
// Result predictor and checker for the TFTP write receiver.
module wrq_transfer_checker import twr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  twr_rx_if    rx_i,
  twr_tx_if    tx_i,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HeaderLen     = 4;
  localparam int MinRequestLen = 6;

  typedef struct packed {
    res_t r;
    logic last;
  } awaited_t;

  awaited_t    awaited_results[$];
  logic        in_xfer;
  logic [15:0] next_block;
  int          pkt_len;
  logic [15:0] opcode;
  logic [15:0] block_seen;
  int          name_len;
  phase_e      phase;
  int          mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic res_t make_result(kind_e kind, logic [7:0] data, logic [15:0] block,
                                       logic [2:0] code, logic over);
    res_t r;
    r.kind  = kind;
    r.data  = data;
    r.block = block;
    r.code  = code;
    r.over  = over;
    return r;
  endfunction

  function automatic void clear_packet();
    pkt_len    = 0;
    opcode     = 16'd0;
    block_seen = 16'd0;
    name_len   = 0;
    phase      = PH_NAME;
  endfunction

  // Works out the results one accepted byte causes and queues them in order.
  function automatic void predict_byte(logic [7:0] b, logic last, logic fault);
    res_t     made [2];
    awaited_t entry;
    int       n;
    int       pos;
    n = 0;
    if (pkt_len < MaxPacketDef) begin
      pos = pkt_len;
      pkt_len++;
      if (pos < 2) begin
        opcode = {opcode[7:0], b};
      end else if (in_xfer) begin
        if (pos < HeaderLen) begin
          block_seen = {block_seen[7:0], b};
        end else if (opcode == OP_DATA && block_seen == next_block) begin
          made[n] = make_result(KIND_DATA, b, 16'd0, ERR_NONE, 1'b0);
          n++;
        end
      end else if (opcode == OP_WRQ) begin
        case (phase)
          PH_NAME: begin
            if (b == 8'd0) begin
              phase = PH_MODE;
            end else if (name_len + 1 >= NameBytesDef) begin
              phase = PH_LONG;
            end else begin
              name_len++;
              made[n] = make_result(KIND_NAME, b, 16'd0, ERR_NONE, 1'b0);
              n++;
            end
          end
          PH_MODE: begin
            if (b == 8'd0) phase = PH_DONE;
          end
          default: ;
        endcase
      end
    end

    if (last) begin
      if (!in_xfer) begin
        if (pkt_len >= MinRequestLen && opcode == OP_WRQ && phase == PH_DONE) begin
          if (fault) begin
            made[n] = make_result(KIND_ERROR, 8'd0, 16'd0, ERR_ACCESS, 1'b1);
          end else begin
            made[n] = make_result(KIND_ACK, 8'd0, 16'd0, ERR_NONE, 1'b0);
            in_xfer    = 1'b1;
            next_block = 16'd1;
          end
          n++;
        end
      end else if (pkt_len < HeaderLen) begin
        in_xfer = 1'b0;
      end else if (opcode == OP_DATA && block_seen == next_block) begin
        if (fault && pkt_len > HeaderLen) begin
          made[n] = make_result(KIND_ERROR, 8'd0, 16'd0, ERR_DISK, 1'b1);
          in_xfer = 1'b0;
        end else if (pkt_len - HeaderLen < BlockBytesDef) begin
          made[n] = make_result(KIND_ACK, 8'd0, next_block, ERR_NONE, 1'b1);
          in_xfer = 1'b0;
        end else begin
          made[n] = make_result(KIND_ACK, 8'd0, next_block, ERR_NONE, 1'b0);
          next_block = next_block + 16'd1;
        end
        n++;
      end else if (opcode == OP_DATA && block_seen < next_block) begin
        made[n] = make_result(KIND_ACK, 8'd0, block_seen, ERR_NONE, 1'b0);
        n++;
      end else if (opcode == OP_ERR_PKT) begin
        in_xfer = 1'b0;
      end else begin
        made[n] = make_result(KIND_ERROR, 8'd0, 16'd0, ERR_ILLEGAL, 1'b1);
        in_xfer = 1'b0;
        n++;
      end
      clear_packet();
    end

    for (int i = 0; i < n; i++) begin
      entry.r    = made[i];
      entry.last = (i == n - 1);
      awaited_results.push_back(entry);
    end
  endfunction

  function automatic void compare_field(string field, logic [15:0] want, logic [15:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, seen);
      mismatches++;
    end
  endfunction

  // Prediction runs before comparison; a byte never shows a result at its own edge.
  always @(posedge clk_i or negedge rst_ni) begin
    awaited_t want;
    if (!rst_ni) begin
      in_xfer    = 1'b0;
      next_block = 16'd1;
      clear_packet();
      awaited_results.delete();
    end else begin
      if (rx_i.valid && rx_i.ready) begin
        predict_byte(rx_i.rx_byte, rx_i.rx_last, rx_i.sink_fault);
      end
      if (tx_i.valid && tx_i.ready) begin
        if (awaited_results.size() == 0) begin
          $display({"%0t: unexpected result, expected none, ",
                    "got kind %0d byte %0d block %0d code %0d"},
                   $time, tx_i.out_kind, tx_i.out_byte, tx_i.out_block, tx_i.out_error_code);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("out_kind", 16'(want.r.kind), 16'(tx_i.out_kind));
          compare_field("out_byte", 16'(want.r.data), 16'(tx_i.out_byte));
          compare_field("out_block", want.r.block, tx_i.out_block);
          compare_field("out_error_code", 16'(want.r.code), 16'(tx_i.out_error_code));
          compare_field("transfer_over", 16'(want.r.over), 16'(tx_i.transfer_over));
          compare_field("out_last", 16'(want.last), 16'(tx_i.out_last));
        end
      end
    end
    pending_o = awaited_results.size();
  end

endmodule

/* dv/tb_tftp_write_receiver.sv */
// Testbench top for the TFTP write receiver: clock, reset, packet stimulus and verdict.
module tb_tftp_write_receiver import twr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkPeriod    = 20;
  localparam int ResetCycles  = 12;
  localparam int CycleLimit   = 600000;
  localparam int HoldCycles   = 400;
  localparam int SettleCycles = 16;
  localparam int RandomItems  = 400;

  // Opcodes the block does not act on; the package only names the ones it does.
  localparam logic [15:0] OP_RRQ     = 16'd1;
  localparam logic [15:0] OP_ACK     = 16'd4;
  localparam logic [15:0] OP_UNKNOWN = 16'hFFFF;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   fail_count;
  int   awaiting;
  int   cycle_count = 0;
  int   hold_reqs = 0;
  int   burst_left = 0;
  int   shipped = 0;
  int   full_budget = 1;

  // Bytes of the packet being assembled, sent in order by ship().
  logic [7:0] frame [$];

  twr_rx_if rx_if ();
  twr_tx_if tx_if ();

  tftp_write_receiver DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .tx_o   (tx_if)
  );

  // The checker sits beside the block, watches both channels, predicts every
  // result and reports how many fields went wrong and how many are still due.
  wrq_transfer_checker u_transfer_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_i         (rx_if),
    .tx_i         (tx_if),
    .fail_count_o (fail_count),
    .pending_o    (awaiting)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result receiver. It switches at random between these stall behaviors:
  // always ready, coin flips, mostly ready, or a fixed repeating pattern.
  // A new hold request from the stimulus turns into a long stretch of stalls
  // that this process counts out itself, so the internal queue fills up and
  // the block has to stop taking bytes.
  initial begin
    int hold_left;
    int holds_taken;
    int mode_left;
    int mode;
    int beat;
    hold_left = 0;
    holds_taken = 0;
    mode_left = 0;
    mode = 0;
    beat = 0;
    tx_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_reqs != holds_taken) begin
        holds_taken = hold_reqs;
        hold_left = HoldCycles;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 128);
      end
      mode_left--;
      beat++;
      if (hold_left > 0) begin
        hold_left--;
        tx_if.ready = 1'b0;
      end else begin
        case (mode)
          0: tx_if.ready = 1'b1;
          1: tx_if.ready = 1'($urandom_range(0, 1));
          2: tx_if.ready = ($urandom_range(0, 3) != 0);
          default: tx_if.ready = (beat % 5 != 2) && (beat % 7 != 0);
        endcase
      end
    end
  end

  // Offers one byte and returns at the falling edge after it was taken.
  // The sender runs in bursts of random length; before a new burst it may
  // drop valid for a random gap. About a third of the bursts start with no
  // gap at all, which gives back-to-back stretches.
  task automatic send_byte(input logic [7:0] b, input logic last, input logic fault);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        rx_if.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    rx_if.rx_byte    = b;
    rx_if.rx_last    = last;
    rx_if.sink_fault = fault;
    rx_if.valid      = 1'b1;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Sends the assembled packet. The fault flag only matters on the last byte;
  // the other bytes carry a random one so that the block must ignore it there.
  task automatic ship(input logic fault);
    int   i;
    logic flag;
    for (i = 0; i < frame.size(); i++) begin
      flag = (i == frame.size() - 1) ? fault : 1'($urandom_range(0, 1));
      send_byte(frame[i], i == frame.size() - 1, flag);
    end
    shipped += frame.size();
    frame.delete();
  endtask

  // Lets the sender go quiet until every predicted result has come out.
  task automatic drain_results();
    rx_if.valid = 1'b0;
    wait (awaiting == 0);
    @(negedge clk_i);
  endtask

  task automatic put_word(input logic [15:0] w);
    frame.push_back(w[15:8]);
    frame.push_back(w[7:0]);
  endtask

  task automatic add_random(input int n);
    repeat (n) frame.push_back(8'($urandom_range(0, 255)));
  endtask

  // Request packet: opcode, non-zero name bytes, terminator, non-zero mode
  // bytes, terminator. Either terminator can be left out to break it.
  task automatic build_request(input logic [15:0] op, input int name_len, input int mode_len,
                               input logic name_term, input logic mode_term);
    put_word(op);
    repeat (name_len) frame.push_back(8'($urandom_range(1, 255)));
    if (name_term) frame.push_back(8'd0);
    repeat (mode_len) frame.push_back(8'($urandom_range(1, 255)));
    if (mode_term) frame.push_back(8'd0);
  endtask

  task automatic build_data(input logic [15:0] blk, input int n);
    put_word(OP_DATA);
    put_word(blk);
    add_random(n);
  endtask

  initial begin
    int          name_len;
    int          mode_len;
    int          k;
    logic        fault;
    logic        xfer_open;
    logic [15:0] next_blk;
    logic [15:0] op;

    rst_ni           = 1'b0;
    rx_if.valid      = 1'b0;
    rx_if.rx_byte    = 8'd0;
    rx_if.rx_last    = 1'b0;
    rx_if.sink_fault = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // ---------------------------------------------------------------------
    // Directed packets.
    // ---------------------------------------------------------------------

    // While idle, a bare opcode, a one-byte packet, a read request and an
    // unknown opcode are all dropped without any answer.
    put_word(OP_WRQ);
    ship(1'b0);
    frame.push_back(8'hFF);
    ship(1'b1);
    build_request(OP_RRQ, 3, 5, 1'b1, 1'b1);
    ship(1'b0);
    put_word(OP_UNKNOWN);
    add_random(8);
    ship(1'b0);

    // Broken write requests: too short (one name byte, both terminators, five
    // bytes in all), name never terminated, name as long as the name limit,
    // mode never terminated. Name bytes that already went out stay out, but
    // none of these gets an answer.
    build_request(OP_WRQ, 1, 0, 1'b1, 1'b1);
    ship(1'b0);
    build_request(OP_WRQ, 4, 0, 1'b0, 1'b0);
    ship(1'b0);
    build_request(OP_WRQ, NameBytesDef, 5, 1'b1, 1'b1);
    ship(1'b0);
    build_request(OP_WRQ, 3, 5, 1'b1, 1'b0);
    ship(1'b0);

    // Longest legal name, but the host cannot open the file: access error.
    build_request(OP_WRQ, NameBytesDef - 1, 5, 1'b1, 1'b1);
    ship(1'b1);

    // Good request with junk after the mode string, then a long transfer:
    // duplicate of block 0, a full block with an oversized tail that is
    // dropped while the receiver holds off for a long time, a stale
    // duplicate, and finally an empty block with the fault flag up, which
    // still ends the transfer with a plain ack because nothing had to be
    // written.
    build_request(OP_WRQ, 2, 5, 1'b1, 1'b1);
    add_random(3);
    ship(1'b0);
    build_data(16'd0, 3);
    ship(1'b0);
    hold_reqs++;
    build_data(16'd1, MaxPacketDef + 8);
    frame[4] = 8'h00;
    frame[5] = 8'hFF;
    ship(1'b0);
    build_data(16'd1, 7);
    ship(1'b0);
    build_data(16'd2, 0);
    ship(1'b1);

    // Empty file name; first block hits a write fault: disk error.
    build_request(OP_WRQ, 0, 4, 1'b1, 1'b1);
    ship(1'b0);
    build_data(16'd1, 10);
    ship(1'b1);

    // A runt packet in the middle of a transfer ends it quietly.
    build_request(OP_WRQ, 5, 5, 1'b1, 1'b1);
    ship(1'b0);
    add_random(3);
    ship(1'b0);

    // So does an error packet from the client.
    build_request(OP_WRQ, 5, 5, 1'b1, 1'b1);
    ship(1'b0);
    put_word(OP_ERR_PKT);
    put_word(16'd1);
    add_random(2);
    frame.push_back(8'd0);
    ship(1'b0);

    // A block from the future, an ack packet and a second write request all
    // count as illegal operations during a transfer.
    build_request(OP_WRQ, 5, 5, 1'b1, 1'b1);
    ship(1'b0);
    build_data(OP_UNKNOWN, 4);
    ship(1'b0);
    build_request(OP_WRQ, 5, 5, 1'b1, 1'b1);
    ship(1'b0);
    put_word(OP_ACK);
    put_word(16'd0);
    ship(1'b0);
    build_request(OP_WRQ, 5, 5, 1'b1, 1'b1);
    ship(1'b0);
    build_request(OP_WRQ, 2, 3, 1'b1, 1'b1);
    ship(1'b0);

    // Ordinary one-block file.
    build_request(OP_WRQ, 6, 5, 1'b1, 1'b1);
    ship(1'b0);
    build_data(16'd1, 20);
    ship(1'b0);

    // The sender stops here until everything predicted so far has come out.
    drain_results();

    // ---------------------------------------------------------------------
    // Random sessions. Most are well-formed write requests followed by a few
    // data packets (duplicates, now and then a full block) and an ending of
    // some kind; the rest are noise packets with arbitrary opcodes and lengths.
    // ---------------------------------------------------------------------
    shipped = 0;
    while (shipped < RandomItems) begin
      if ($urandom_range(0, 4) == 0) begin
        k = $urandom_range(1, 14);
        case ($urandom_range(0, 5))
          0: op = OP_RRQ;
          1: op = OP_WRQ;
          2: op = OP_DATA;
          3: op = OP_ACK;
          4: op = OP_ERR_PKT;
          default: op = 16'($urandom);
        endcase
        put_word(op);
        add_random(12);
        while (frame.size() > k) void'(frame.pop_back());
        ship(1'($urandom_range(0, 1)));
      end else begin
        name_len = $urandom_range(0, 20);
        mode_len = $urandom_range(0, 8);
        xfer_open = ($urandom_range(0, 15) != 0);
        build_request(OP_WRQ, name_len, mode_len, xfer_open || $urandom_range(0, 1),
                      xfer_open);
        fault = ($urandom_range(0, 9) == 0);
        ship(fault);
        xfer_open = xfer_open && !fault && (name_len + mode_len >= 2);

        if (xfer_open) begin
          next_blk = 16'd1;
          repeat ($urandom_range(0, 4)) begin
            if (full_budget > 0 && $urandom_range(0, 5) == 0) begin
              // Full block, sometimes with an oversized tail.
              full_budget--;
              k = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
              build_data(next_blk, BlockBytesDef + k);
              ship(1'b0);
              next_blk = next_blk + 16'd1;
            end else begin
              // Duplicate of an earlier block: re-acked, data not passed.
              build_data(16'($urandom_range(0, next_blk - 1)), $urandom_range(0, 24));
              ship(1'($urandom_range(0, 1)));
            end
          end

          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
              build_data(next_blk, $urandom_range(0, 40));
              ship($urandom_range(0, 5) == 0);
            end
            5: begin
              put_word(OP_ERR_PKT);
              put_word(16'($urandom_range(0, 7)));
              add_random($urandom_range(0, 6));
              frame.push_back(8'd0);
              ship(1'($urandom_range(0, 1)));
            end
            6: begin
              add_random($urandom_range(1, 3));
              ship(1'($urandom_range(0, 1)));
            end
            7: begin
              build_data(next_blk + 16'($urandom_range(1, 300)), $urandom_range(0, 10));
              ship(1'($urandom_range(0, 1)));
            end
            8: begin
              case ($urandom_range(0, 3))
                0: op = OP_RRQ;
                1: op = OP_WRQ;
                2: op = OP_ACK;
                default: op = 16'($urandom_range(6, 65535));
              endcase
              put_word(op);
              add_random($urandom_range(2, 10));
              ship(1'($urandom_range(0, 1)));
            end
            default: ;  // left open; the next request then arrives mid-transfer
          endcase
        end
      end
      if ($urandom_range(0, 7) == 0) drain_results();
    end

    // Wind down: stop offering bytes, let the last results come out, then
    // let the block run on idle so that anything it should not show comes out.
    rx_if.valid = 1'b0;
    wait (awaiting == 0);
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
